[hw/rtl/quaternion_to_euler_degrees_top_defines.svh]
// assertion macros used by the checker file
`ifndef QUATERNION_TO_EULER_DEGREES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_DEGREES_TOP_DEFINES_SVH

// concurrent assertion, disabled while reset is high
`define Q2E_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define Q2E_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/q2e_pkg.sv]
// shared types, widths and the arctangent table for the quaternion to euler block
package q2e_pkg;

  localparam int CW = 37;  // cordic x/y width
  localparam int ZW = 26;  // angle width, 2^-16 degree units
  localparam int RW = 64;  // square root remainder width
  localparam int QW = 31;  // square root result width

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] root;
  } sq_t;

  localparam logic signed [ZW-1:0] ANG_180 = 26'sd11796480;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_ang(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

[hw/rtl/quaternion_to_euler_degrees_top.sv]
// quaternion to roll, pitch and yaw in 1/128 degree, fully pipelined
//
// input stream: one quaternion per transfer, s_tdata = w, x, y, z (Q1.15).
// output stream: one result per input transfer, in order; roll, pitch and
// yaw in m_tdata, gimbal lock and zero-quaternion flags in m_tuser.
// throughput: one transfer per cycle, sustained while m_tready is high.
// pipeline: four product/sum stages, 31 square root cells, one fold and six
// normalize stages, the cordic cells, one output register.
// every stage moves on one common enable; when m_tvalid is high and
// m_tready low the whole pipeline holds and s_tready drops in the same cycle.
// bubbles travel with the data, so s_tready is high whenever the output
// register is empty or being taken.
// reset (rst, synchronous) clears all stage valid bits; no result is
// pending afterwards.
module quaternion_to_euler_degrees_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // q_w, q_x, q_y, q_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // roll_deg, pitch_deg, yaw_deg, zero pad
  output logic [1:0]  m_tuser    // pitch_clamped, degenerate
);
  localparam int ZW    = q2e_pkg::ZW;
  localparam int RUN   = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int LAT_A = 7 + RUN;
  localparam int NQ    = 31;

  typedef struct packed {
    logic               valid;
    logic signed [35:0] ya;
    logic signed [35:0] yb;
    logic signed [35:0] ra;
    logic signed [35:0] rb;
    logic [29:0]        smh;
    logic               neg;
    logic               clamped;
    logic               degen;
  } side_t;

  typedef struct packed {
    logic valid;
    logic clamped;
    logic neg;
    logic degen;
  } flag_t;

  function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] z,
                                               input logic signed [17:0] lim);
    logic signed [ZW:0] t;
    logic signed [17:0] r;
    t = {z[ZW-1], z} + (ZW+1)'(256);
    r = 18'(t >>> 9);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  logic en;

  logic               v0;
  logic signed [15:0] w0, x0, y0, z0;

  logic               v1;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_wz, p_xy, p_wx, p_yz, p_wy, p_zx;

  logic signed [35:0] ya_next, yb_next, ra_next, rb_next, s_next, n_next, sm_next;
  logic               v2;
  logic signed [35:0] ya2, yb2, ra2, rb2;
  logic [32:0]        n2, sm2;
  logic               neg2, clamped2, degen2;

  logic [32:0]        nsh, ssh;
  logic [30:0]        dif, sum;
  logic [61:0]        prod_next;

  side_t              sd [NQ+1];
  q2e_pkg::sq_t       sq [NQ+1];

  logic signed [35:0] sv, cx;
  logic signed [ZW-1:0] yaw_ang, roll_ang, pitch_ang;
  flag_t              fl [LAT_A];
  flag_t              fo;

  logic signed [15:0] roll_o, yaw_o, pitch_w;
  logic               out_valid;
  logic signed [15:0] roll_r, yaw_r;
  logic [14:0]        pitch_r;
  logic               clamp_r, degen_r;

  assign en       = m_tready || !out_valid;
  assign s_tready = en;

  // capture
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_tvalid;
    if (en) begin
      w0 <= s_tdata[15:0];
      x0 <= s_tdata[31:16];
      y0 <= s_tdata[47:32];
      z0 <= s_tdata[63:48];
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      p_ww <= w0 * w0;
      p_xx <= x0 * x0;
      p_yy <= y0 * y0;
      p_zz <= z0 * z0;
      p_wz <= w0 * z0;
      p_xy <= x0 * y0;
      p_wx <= w0 * x0;
      p_yz <= y0 * z0;
      p_wy <= w0 * y0;
      p_zx <= z0 * x0;
    end
  end

  // rotation matrix terms, scaled by the squared norm
  always_comb begin
    ya_next = (36'(p_wz) + 36'(p_xy)) <<< 1;
    yb_next = 36'(p_ww) + 36'(p_xx) - 36'(p_yy) - 36'(p_zz);
    ra_next = (36'(p_wx) + 36'(p_yz)) <<< 1;
    rb_next = 36'(p_ww) - 36'(p_xx) - 36'(p_yy) + 36'(p_zz);
    s_next  = (36'(p_wy) - 36'(p_zx)) <<< 1;
    n_next  = 36'(p_ww) + 36'(p_xx) + 36'(p_yy) + 36'(p_zz);
    sm_next = s_next[35] ? -s_next : s_next;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      ya2      <= ya_next;
      yb2      <= yb_next;
      ra2      <= ra_next;
      rb2      <= rb_next;
      n2       <= n_next[32:0];
      sm2      <= sm_next[32:0];
      neg2     <= s_next[35];
      clamped2 <= sm_next[32:0] >= n_next[32:0];
      degen2   <= n_next == '0;
    end
  end

  // bring the norm below 2^30, then form n^2 - s^2
  always_comb begin
    priority if (n2[32]) begin
      nsh = n2 >> 3;
      ssh = sm2 >> 3;
    end else if (n2[31]) begin
      nsh = n2 >> 2;
      ssh = sm2 >> 2;
    end else if (n2[30]) begin
      nsh = n2 >> 1;
      ssh = sm2 >> 1;
    end else begin
      nsh = n2;
      ssh = sm2;
    end
    dif       = {1'b0, nsh[29:0]} - {1'b0, ssh[29:0]};
    sum       = {1'b0, nsh[29:0]} + {1'b0, ssh[29:0]};
    prod_next = dif * sum;
  end

  always_ff @(posedge clk) begin
    if (rst) sd[0].valid <= 1'b0;
    else if (en) sd[0].valid <= v2;
    if (en) begin
      sd[0].ya      <= ya2;
      sd[0].yb      <= yb2;
      sd[0].ra      <= ra2;
      sd[0].rb      <= rb2;
      sd[0].smh     <= ssh[29:0];
      sd[0].neg     <= neg2;
      sd[0].clamped <= clamped2;
      sd[0].degen   <= degen2;
      sq[0].rem     <= {2'b00, prod_next};
      sq[0].root    <= '0;
    end
  end

  // square root, one result bit per cell, side data alongside
  for (genvar k = 0; k < NQ; k++) begin : g_sqrt
    q2e_sqrt_cell #(.BIT(NQ - 1 - k)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (sq[k]),
      .q   (sq[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) sd[k+1].valid <= 1'b0;
      else if (en) sd[k+1] <= sd[k];
    end
  end

  assign sv = sd[NQ].neg ? -$signed({6'b0, sd[NQ].smh}) : $signed({6'b0, sd[NQ].smh});
  assign cx = $signed({5'b0, sq[NQ].root});

  q2e_atan2 #(.STAGES(CORDIC_STAGES), .IN_W(36)) u_yaw (
    .clk (clk), .en (en), .y_in (sd[NQ].ya), .x_in (sd[NQ].yb), .ang (yaw_ang)
  );

  q2e_atan2 #(.STAGES(CORDIC_STAGES), .IN_W(36)) u_roll (
    .clk (clk), .en (en), .y_in (sd[NQ].ra), .x_in (sd[NQ].rb), .ang (roll_ang)
  );

  q2e_atan2 #(.STAGES(CORDIC_STAGES), .IN_W(36)) u_pitch (
    .clk (clk), .en (en), .y_in (sv), .x_in (cx), .ang (pitch_ang)
  );

  // flags ride along the cordic latency
  always_ff @(posedge clk) begin
    if (rst) fl[0].valid <= 1'b0;
    else if (en) begin
      fl[0].valid   <= sd[NQ].valid;
      fl[0].clamped <= sd[NQ].clamped;
      fl[0].neg     <= sd[NQ].neg;
      fl[0].degen   <= sd[NQ].degen;
    end
  end

  for (genvar j = 1; j < LAT_A; j++) begin : g_flag
    always_ff @(posedge clk) begin
      if (rst) fl[j].valid <= 1'b0;
      else if (en) fl[j] <= fl[j-1];
    end
  end

  assign fo = fl[LAT_A-1];

  always_comb begin
    roll_o = to_out(roll_ang, 18'sd23040);
    yaw_o  = to_out(yaw_ang, 18'sd23040);
    if (fo.clamped) pitch_w = fo.neg ? -16'sd11520 : 16'sd11520;
    else pitch_w = to_out(pitch_ang, 18'sd11520);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= fo.valid;
    if (en) begin
      roll_r  <= fo.degen ? '0 : roll_o;
      yaw_r   <= fo.degen ? '0 : yaw_o;
      pitch_r <= fo.degen ? '0 : pitch_w[14:0];
      clamp_r <= fo.clamped && !fo.degen;
      degen_r <= fo.degen;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, yaw_r, pitch_r, roll_r};
  assign m_tuser  = {degen_r, clamp_r};
endmodule

[hw/rtl/q2e_sqrt_cell.sv]
// one result bit of the pipelined integer square root
module q2e_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  q2e_pkg::sq_t  d,
  output q2e_pkg::sq_t  q
);
  localparam int RW = q2e_pkg::RW;
  localparam int QW = q2e_pkg::QW;

  logic [RW-1:0] trial;
  q2e_pkg::sq_t  q_next;

  // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
  always_comb begin
    trial  = ({{(RW-QW){1'b0}}, d.root} << (BIT + 1)) + (RW'(1) << (2 * BIT));
    q_next = d;
    if (trial <= d.rem) begin
      q_next.rem  = d.rem - trial;
      q_next.root = d.root | (QW'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end
endmodule

[hw/rtl/q2e_cordic_cell.sv]
// one vectoring rotation of the cordic chain
module q2e_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  q2e_pkg::cordic_t d,
  output q2e_pkg::cordic_t q
);
  localparam int CW = q2e_pkg::CW;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  q2e_pkg::cordic_t     q_next;

  always_comb begin
    dx     = d.y >>> IDX;
    dy     = d.x >>> IDX;
    q_next = d;
    if (!d.y[CW-1]) begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + q2e_pkg::atan_ang(IDX);
    end else begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - q2e_pkg::atan_ang(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end
endmodule

[hw/rtl/q2e_atan2.sv]
// pipelined atan2: quadrant fold, staged normalize, chain of cordic cells
module q2e_atan2 #(
  parameter int STAGES = 16,
  parameter int IN_W   = 36
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [IN_W-1:0]         y_in,
  input  logic signed [IN_W-1:0]         x_in,
  output logic signed [q2e_pkg::ZW-1:0]  ang
);
  localparam int CW  = q2e_pkg::CW;
  localparam int MW  = 34;
  localparam int NS  = 6;
  localparam int RUN = (STAGES < 24) ? STAGES : 24;

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  q2e_pkg::cordic_t     p_next;
  logic [MW-1:0]        m_next;

  q2e_pkg::cordic_t     nrm [NS+1];
  logic [MW-1:0]        nm  [NS+1];
  q2e_pkg::cordic_t     cc  [RUN+1];

  // fold the left half plane onto the right one
  always_comb begin
    xe = {{(CW-IN_W){x_in[IN_W-1]}}, x_in};
    ye = {{(CW-IN_W){y_in[IN_W-1]}}, y_in};
    p_next.zero = (xe == '0) && (ye == '0);
    if (xe[CW-1]) begin
      p_next.x = -xe;
      p_next.y = -ye;
      p_next.z = ye[CW-1] ? -q2e_pkg::ANG_180 : q2e_pkg::ANG_180;
    end else begin
      p_next.x = xe;
      p_next.y = ye;
      p_next.z = '0;
    end
    ax     = p_next.x[CW-1] ? -p_next.x : p_next.x;
    ay     = p_next.y[CW-1] ? -p_next.y : p_next.y;
    m_next = (ax > ay) ? ax[MW-1:0] : ay[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm[0] <= p_next;
      nm[0]  <= m_next;
    end
  end

  // scale up until the larger magnitude reaches 2^32
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    q2e_pkg::cordic_t stage_next;
    logic [MW-1:0]    mag_next;

    always_comb begin
      stage_next = nrm[j];
      mag_next   = nm[j];
      if (nm[j] < (MW'(1) << (33 - SH))) begin
        stage_next.x = nrm[j].x <<< SH;
        stage_next.y = nrm[j].y <<< SH;
        mag_next     = nm[j] << SH;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm[j+1] <= stage_next;
        nm[j+1]  <= mag_next;
      end
    end
  end

  assign cc[0] = nrm[NS];

  for (genvar i = 0; i < RUN; i++) begin : g_cell
    q2e_cordic_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (cc[i]),
      .q   (cc[i+1])
    );
  end

  assign ang = cc[RUN].zero ? '0 : cc[RUN].z;
endmodule

[hw/rtl/q2e_checker.sv]
// port-level checks for the quaternion to euler block, bound to the top level
`include "quaternion_to_euler_degrees_top_defines.svh"

module q2e_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);
  `Q2E_ASSERT_NR(a_rst_empty, clk, rst |=> !m_tvalid, "output valid after reset")
  `Q2E_ASSERT(a_stall_blocks, clk, rst, m_tvalid && !m_tready |-> !s_tready, "input while stalled")
  `Q2E_ASSERT(a_stall_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stall changed")
  `Q2E_ASSERT(a_degen_zero, clk, rst, m_tvalid && m_tuser[1] |-> m_tdata[46:0] == 47'd0 && !m_tuser[0], "zero quat")
  `Q2E_ASSERT(a_clamp_pitch, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata[30:16] == 15'd11520 || m_tdata[30:16] == 15'd21248, "clamp")
endmodule

bind quaternion_to_euler_degrees_top q2e_port_checks u_q2e_port_checks (.*);
